// ----- hdl/nmv_pkg.sv -----
// ============================================================================
// nmv_pkg
// Shared types and constants of the mirrored nametable video RAM.
// ============================================================================
package nmv_pkg;

    localparam int VRAM_BYTES = 2048;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);
    localparam int DATA_W     = 8;
    localparam int WIN_W      = 12;
    localparam int TILE_W     = 6;

    localparam logic [TILE_W-1:0] PLANE_ROWS = TILE_W'(60);
    localparam logic [TILE_W-1:0] TABLE_ROWS = TILE_W'(30);
    localparam logic [3:0]        ATTR_ROW   = 4'b1111;

    typedef enum logic [1:0] {
        FUNC_READ    = 2'd0,
        FUNC_WRITE   = 2'd1,
        FUNC_TILE    = 2'd2,
        FUNC_PALETTE = 2'd3
    } func_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } state_t;

    typedef struct packed {
        logic [VRAM_AW-1:0] idx;
        logic [1:0]         quad;
    } map_t;

endpackage

// ----- hdl/nmv_ram.sv -----
// ============================================================================
// nmv_ram
// Single-port synchronous RAM with registered read.
// ============================================================================
module nmv_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ----- hdl/nmv_addr.sv -----
// ============================================================================
// nmv_addr
// Fold a nametable access onto the RAM index under the mirroring mode.
// ============================================================================
module nmv_addr (
    input  logic [1:0]                   func,
    input  logic [13:0]                  address,
    input  logic [nmv_pkg::TILE_W-1:0]   tile_x,
    input  logic [nmv_pkg::TILE_W-1:0]   tile_y,
    input  logic                         mirroring_mode,
    output nmv_pkg::map_t                map
);

    logic [nmv_pkg::TILE_W-1:0] y_wrap;
    logic                       table_y;
    logic [nmv_pkg::TILE_W-1:0] row_full;
    logic [4:0]                 row;
    logic [4:0]                 col;
    logic [nmv_pkg::WIN_W-1:0]  win;

    always_comb begin
        y_wrap   = (tile_y >= nmv_pkg::PLANE_ROWS) ? tile_y - nmv_pkg::PLANE_ROWS : tile_y;
        table_y  = (y_wrap >= nmv_pkg::TABLE_ROWS);
        row_full = table_y ? y_wrap - nmv_pkg::TABLE_ROWS : y_wrap;
        row      = row_full[4:0];
        col      = tile_x[4:0];

        unique case (nmv_pkg::func_t'(func))
            nmv_pkg::FUNC_TILE:
                win = {table_y, tile_x[5], row, col};
            nmv_pkg::FUNC_PALETTE:
                win = {table_y, tile_x[5], nmv_pkg::ATTR_ROW, row[4:2], col[4:2]};
            default:
                win = address[nmv_pkg::WIN_W-1:0];
        endcase

        if (mirroring_mode) begin
            map.idx = win[nmv_pkg::VRAM_AW-1:0];
        end else begin
            map.idx = {win[11], win[9:0]};
        end
        map.quad = {row[1], col[1]};
    end

endmodule

// ----- hdl/nametable_mirrored_vram.sv -----
// ============================================================================
// nametable_mirrored_vram
// 2 KiB nametable video RAM behind a mirrored 4 KiB window.
// ============================================================================
// After reset the block zeroes its RAM, one byte a cycle, and holds s_ready low
// meanwhile; mirroring writes are taken at any time. Then one beat is accepted
// per cycle unless the output stalls; each beat accesses the single RAM port and
// its result is registered in the RAM read data, then in m_data once the output
// is free. A result waiting on m_ready holds at most one more beat behind it.
// Reads and tile lookups return RAM data, palette lookups two bits; writes zero.
module nametable_mirrored_vram (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic [13:0]                s_address,
    input  logic [7:0]                 s_write_data,
    input  logic [5:0]                 s_tile_x,
    input  logic [5:0]                 s_tile_y,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_data
);

    nmv_pkg::state_t               state_reg, state_next;
    logic [nmv_pkg::VRAM_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                          mirroring_reg;
    logic                          pend_valid_reg, pend_valid_next;
    nmv_pkg::func_t                pend_func_reg;
    logic [1:0]                    pend_quad_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [7:0]                    m_data_reg;
    logic [7:0]                    result;
    logic                          out_free;
    logic                          accept;
    logic                          advance;
    nmv_pkg::map_t                 map;
    logic                          ram_en;
    logic                          ram_we;
    logic [nmv_pkg::VRAM_AW-1:0]   ram_addr;
    logic [7:0]                    ram_wdata;
    logic [7:0]                    ram_rdata;

    nmv_addr u_addr (
        .func           (s_func),
        .address        (s_address),
        .tile_x         (s_tile_x),
        .tile_y         (s_tile_y),
        .mirroring_mode (mirroring_reg),
        .map            (map)
    );

    nmv_ram #(
        .DEPTH (nmv_pkg::VRAM_BYTES),
        .WIDTH (nmv_pkg::DATA_W)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = pend_valid_reg && out_free;
    assign s_ready  = (state_reg == nmv_pkg::ST_RUN) && (!pend_valid_reg || out_free);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // clear sweep, then run
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        ram_en       = accept;
        ram_we       = accept && (nmv_pkg::func_t'(s_func) == nmv_pkg::FUNC_WRITE);
        ram_addr     = map.idx;
        ram_wdata    = s_write_data;
        unique case (state_reg)
            nmv_pkg::ST_CLEAR: begin
                ram_en       = 1'b1;
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == nmv_pkg::VRAM_AW'(nmv_pkg::VRAM_BYTES - 1)) begin
                    state_next = nmv_pkg::ST_RUN;
                end
            end
            nmv_pkg::ST_RUN: begin
            end
            default: begin
                state_next = nmv_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        pend_valid_next = accept ? 1'b1 : (out_free ? 1'b0 : pend_valid_reg);
        m_valid_next    = advance ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        case (pend_func_reg)
            nmv_pkg::FUNC_WRITE:   result = '0;
            nmv_pkg::FUNC_PALETTE: result = {6'd0, 2'(ram_rdata >> {pend_quad_reg, 1'b0})};
            default:               result = ram_rdata;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= nmv_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            mirroring_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                mirroring_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_func_reg <= nmv_pkg::func_t'(s_func);
            pend_quad_reg <= map.quad;
        end
        if (advance) begin
            m_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_no_beat_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nmv_pkg::ST_CLEAR) |-> !s_ready)
        else $error("input beat taken during RAM clear");

    a_run_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nmv_pkg::ST_RUN) |=> (state_reg == nmv_pkg::ST_RUN))
        else $error("RAM clear restarted without reset");

    a_pend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !out_free) |=>
            (pend_valid_reg && $stable(pend_func_reg) && $stable(pend_quad_reg)
             && $stable(ram_rdata)))
        else $error("stalled pending beat lost its data");

    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (pend_func_reg == nmv_pkg::FUNC_WRITE)) |=> (m_data_reg == 8'd0))
        else $error("write beat returned nonzero data");

    a_palette_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (pend_func_reg == nmv_pkg::FUNC_PALETTE)) |=> (m_data_reg[7:2] == 6'd0))
        else $error("palette result out of range");
`endif

endmodule
